### rtl/round_robin_task_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define RRTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
// Next-cycle implication, disabled while reset is high.
`define RRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define RRTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define RRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/rrts_pkg.sv
// Types and constants shared by the scheduler modules.
package rrts_pkg;
   localparam int NUM_IDS = 16;
   localparam int ID_W    = 4;
   localparam int CNT_W   = 5;

   localparam logic [2:0] ACT_READY   = 3'd0;
   localparam logic [2:0] ACT_UNREADY = 3'd1;
   localparam logic [2:0] ACT_SCHED   = 3'd2;
   localparam logic [2:0] ACT_SLEEP   = 3'd3;
   localparam logic [2:0] ACT_CANCEL  = 3'd4;
   localparam logic [2:0] ACT_TICK    = 3'd5;

   typedef logic [ID_W-1:0] id_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  task_id;
      logic [31:0] amount_ms;
   } req_type;

   typedef struct packed {
      logic [3:0] current_task;
      logic       current_idle;
      logic [4:0] ready_count;
      logic [4:0] woken_count;
      logic       rejected;
   } rsp_type;

   // One access cycle of an ordered id list.
   typedef struct packed {
      id_type rd_addr;
      logic   wr_en;
      id_type wr_addr;
      id_type wr_data;
      logic   set_en;
      id_type set_id;
      logic   clr_en;
      id_type clr_id;
   } rrts_list_cmd_type;
endpackage

### rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler with sleep timeouts.
//
// A transaction is accepted at a rising clock edge with start high and busy
// low; req_data carries action, task id and amount. busy stays high while
// the sequencer works the item. When it finishes, rsp_valid is high for one
// cycle with the status in rsp_data; the receiver cannot stall it.
// Work per action: mark ready, schedule with an empty ring, and rejected or no-op
// actions go straight to the strobe; schedule rotates the ring, moving each entry
// down by one place; mark unready and cancel make one removal scan; sleep
// makes up to two scans and one add; tick adds the amount to the clock, then
// compares the deadline of each sleeper with it.
// One list entry is read and one written per cycle; a single 64-bit adder
// serves both deadline and clock updates. The next transaction may be taken
// in the cycle the strobe is shown.
// Reset clears the ring and sleep lists, the clock and selects the idle task.
module round_robin_task_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   output rrts_pkg::rsp_type rsp_data
);
   `include "round_robin_task_scheduler_macros.svh"

   localparam logic [8:0] MAX_LIM = 9'(rrts_pkg::NUM_IDS);

   typedef enum logic [3:0] {
      S_IDLE, S_RM_RING, S_RM_SLEEP, S_SLEEP_FIN, S_ROTATE,
      S_TICK_ADD, S_TICK_SCAN, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [4:0]        idx_ff, idx_in;
   logic [4:0]        wptr_ff, wptr_in;
   logic              found_ff, found_in;
   rrts_pkg::id_type  target_ff, target_in;
   logic [2:0]        act_ff, act_in;
   logic [31:0]       amt_ff, amt_in;
   rrts_pkg::id_type  head_ff, head_in;
   logic [4:0]        ready_len_ff, ready_len_in;
   logic [4:0]        sleep_len_ff, sleep_len_in;
   logic [63:0]       now_ff, now_in;
   rrts_pkg::id_type  run_task_ff, run_task_in;
   logic              run_idle_ff, run_idle_in;
   logic [4:0]        woken_ff, woken_in;
   logic              rejected_ff, rejected_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rrts_pkg::rsp_type rsp_ff, rsp_in;

   logic [63:0]       deadline_ff [rrts_pkg::NUM_IDS];
   logic              dl_we;
   rrts_pkg::id_type  dl_addr;

   rrts_pkg::rrts_list_cmd_type  ring_cmd, sleep_cmd;
   rrts_pkg::id_type             ring_rd, sleep_rd;
   logic [rrts_pkg::NUM_IDS-1:0] ring_mem, sleep_mem;

   logic [63:0] sum;
   logic [63:0] dl_rd;
   logic        wake;
   logic        ring_full, sleep_full, req_id_ok, run_id_ok;

   rrts_list u_ring (
      .clock(clock), .reset(reset), .cmd(ring_cmd), .rd_data(ring_rd), .member(ring_mem)
   );
   rrts_list u_sleep (
      .clock(clock), .reset(reset), .cmd(sleep_cmd), .rd_data(sleep_rd), .member(sleep_mem)
   );

   // Shared adder and deadline compare.
   assign sum        = now_ff + {32'd0, amt_ff};
   assign dl_rd      = deadline_ff[sleep_rd];
   assign wake       = ({5'd0, sleep_rd} < MAX_LIM) && (now_ff > dl_rd);
   assign ring_full  = {4'd0, ready_len_ff} >= MAX_LIM;
   assign sleep_full = {4'd0, sleep_len_ff} >= MAX_LIM;
   assign req_id_ok  = {5'd0, req_data.task_id} < MAX_LIM;
   assign run_id_ok  = {5'd0, run_task_ff} < MAX_LIM;

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      found_in     = found_ff;
      target_in    = target_ff;
      act_in       = act_ff;
      amt_in       = amt_ff;
      head_in      = head_ff;
      ready_len_in = ready_len_ff;
      sleep_len_in = sleep_len_ff;
      now_in       = now_ff;
      run_task_in  = run_task_ff;
      run_idle_in  = run_idle_ff;
      woken_in     = woken_ff;
      rejected_in  = rejected_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      dl_we        = 1'b0;
      dl_addr      = target_ff;
      ring_cmd     = '0;
      sleep_cmd    = '0;
      ring_cmd.rd_addr  = (state_ff == S_IDLE) ? '0 : idx_ff[3:0];
      sleep_cmd.rd_addr = idx_ff[3:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in      = req_data.action;
               target_in   = req_data.task_id;
               amt_in      = req_data.amount_ms;
               woken_in    = '0;
               rejected_in = 1'b0;
               idx_in      = '0;
               wptr_in     = '0;
               found_in    = 1'b0;
               head_in     = ring_rd;
               state_in    = S_DONE;
               case (req_data.action)
                  rrts_pkg::ACT_READY: begin
                     if (!req_id_ok || ring_mem[req_data.task_id] || ring_full) begin
                        rejected_in = 1'b1;
                     end else begin
                        ring_cmd.wr_en   = 1'b1;
                        ring_cmd.wr_addr = ready_len_ff[3:0];
                        ring_cmd.wr_data = req_data.task_id;
                        ring_cmd.set_en  = 1'b1;
                        ring_cmd.set_id  = req_data.task_id;
                        ready_len_in     = ready_len_ff + 5'd1;
                     end
                  end
                  rrts_pkg::ACT_UNREADY: begin
                     if (req_id_ok && ring_mem[req_data.task_id]) begin
                        state_in = S_RM_RING;
                     end
                  end
                  rrts_pkg::ACT_SCHED: begin
                     if (ready_len_ff == '0) begin
                        run_idle_in = 1'b1;
                        run_task_in = '0;
                     end else begin
                        idx_in   = 5'd1;
                        state_in = S_ROTATE;
                     end
                  end
                  rrts_pkg::ACT_SLEEP: begin
                     if (run_idle_ff || !run_id_ok) begin
                        rejected_in = 1'b1;
                     end else begin
                        target_in = run_task_ff;
                        if (ring_mem[run_task_ff]) begin
                           state_in = S_RM_RING;
                        end else if (sleep_mem[run_task_ff]) begin
                           state_in = S_RM_SLEEP;
                        end else begin
                           state_in = S_SLEEP_FIN;
                        end
                     end
                  end
                  rrts_pkg::ACT_CANCEL: begin
                     if (req_id_ok && sleep_mem[req_data.task_id]) begin
                        state_in = S_RM_SLEEP;
                     end
                  end
                  rrts_pkg::ACT_TICK: begin
                     state_in = S_TICK_ADD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // Remove target from the ring, closing the gap as the scan goes.
         S_RM_RING: begin
            if (idx_ff < ready_len_ff) begin
               if (found_ff) begin
                  ring_cmd.wr_en   = 1'b1;
                  ring_cmd.wr_addr = idx_ff[3:0] - 4'd1;
                  ring_cmd.wr_data = ring_rd;
               end
               if (ring_rd == target_ff) begin
                  found_in = 1'b1;
               end
               idx_in = idx_ff + 5'd1;
            end else begin
               if (found_ff) begin
                  ready_len_in = ready_len_ff - 5'd1;
               end
               ring_cmd.clr_en = 1'b1;
               ring_cmd.clr_id = target_ff;
               idx_in   = '0;
               found_in = 1'b0;
               if (act_ff == rrts_pkg::ACT_SLEEP) begin
                  state_in = sleep_mem[target_ff] ? S_RM_SLEEP : S_SLEEP_FIN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // Remove target from the sleep list.
         S_RM_SLEEP: begin
            if (idx_ff < sleep_len_ff) begin
               if (found_ff) begin
                  sleep_cmd.wr_en   = 1'b1;
                  sleep_cmd.wr_addr = idx_ff[3:0] - 4'd1;
                  sleep_cmd.wr_data = sleep_rd;
               end
               if (sleep_rd == target_ff) begin
                  found_in = 1'b1;
               end
               idx_in = idx_ff + 5'd1;
            end else begin
               if (found_ff) begin
                  sleep_len_in = sleep_len_ff - 5'd1;
               end
               sleep_cmd.clr_en = 1'b1;
               sleep_cmd.clr_id = target_ff;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = (act_ff == rrts_pkg::ACT_SLEEP) ? S_SLEEP_FIN : S_DONE;
            end
         end

         // Store the deadline and file the task at the sleep list tail.
         S_SLEEP_FIN: begin
            dl_we = 1'b1;
            if (!sleep_full) begin
               sleep_cmd.wr_en   = 1'b1;
               sleep_cmd.wr_addr = sleep_len_ff[3:0];
               sleep_cmd.wr_data = target_ff;
               sleep_cmd.set_en  = 1'b1;
               sleep_cmd.set_id  = target_ff;
               sleep_len_in      = sleep_len_ff + 5'd1;
            end
            state_in = S_DONE;
         end

         // Shift the ring down by one and put the old head at the tail.
         S_ROTATE: begin
            if (idx_ff < ready_len_ff) begin
               ring_cmd.wr_en   = 1'b1;
               ring_cmd.wr_addr = idx_ff[3:0] - 4'd1;
               ring_cmd.wr_data = ring_rd;
               if (idx_ff == 5'd1) begin
                  run_task_in = ring_rd;
               end
               idx_in = idx_ff + 5'd1;
            end else begin
               ring_cmd.wr_en   = 1'b1;
               ring_cmd.wr_addr = ready_len_ff[3:0] - 4'd1;
               ring_cmd.wr_data = head_ff;
               if (ready_len_ff == 5'd1) begin
                  run_task_in = head_ff;
               end
               run_idle_in = 1'b0;
               state_in    = S_DONE;
            end
         end

         S_TICK_ADD: begin
            now_in   = sum;
            idx_in   = '0;
            wptr_in  = '0;
            state_in = S_TICK_SCAN;
         end

         // Compact the sleep list, moving expired sleepers to the ring unless already there or full.
         S_TICK_SCAN: begin
            if (idx_ff < sleep_len_ff) begin
               if (wake) begin
                  sleep_cmd.clr_en = 1'b1;
                  sleep_cmd.clr_id = sleep_rd;
                  if (!ring_mem[sleep_rd] && !ring_full) begin
                     ring_cmd.wr_en   = 1'b1;
                     ring_cmd.wr_addr = ready_len_ff[3:0];
                     ring_cmd.wr_data = sleep_rd;
                     ring_cmd.set_en  = 1'b1;
                     ring_cmd.set_id  = sleep_rd;
                     ready_len_in     = ready_len_ff + 5'd1;
                     woken_in         = woken_ff + 5'd1;
                  end
               end else begin
                  sleep_cmd.wr_en   = 1'b1;
                  sleep_cmd.wr_addr = wptr_ff[3:0];
                  sleep_cmd.wr_data = sleep_rd;
                  wptr_in           = wptr_ff + 5'd1;
               end
               idx_in = idx_ff + 5'd1;
            end else begin
               sleep_len_in = wptr_ff;
               state_in     = S_DONE;
            end
         end

         S_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_in.current_task = run_idle_ff ? '0 : run_task_ff;
            rsp_in.current_idle = run_idle_ff;
            rsp_in.ready_count  = ready_len_ff;
            rsp_in.woken_count  = woken_ff;
            rsp_in.rejected     = rejected_ff;
            state_in            = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state, scheduler status and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_len_ff <= '0;
         sleep_len_ff <= '0;
         now_ff       <= '0;
         run_task_ff  <= '0;
         run_idle_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ready_len_ff <= ready_len_in;
         sleep_len_ff <= sleep_len_in;
         now_ff       <= now_in;
         run_task_ff  <= run_task_in;
         run_idle_ff  <= run_idle_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   // Working registers of the current transaction.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      wptr_ff     <= wptr_in;
      found_ff    <= found_in;
      target_ff   <= target_in;
      act_ff      <= act_in;
      amt_ff      <= amt_in;
      head_ff     <= head_in;
      woken_ff    <= woken_in;
      rejected_ff <= rejected_in;
   end

   // Wake deadlines, one per task id.
   always_ff @(posedge clock) begin
      if (dl_we) begin
         deadline_ff[dl_addr] <= sum;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RRTS_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
   `RRTS_ASSERT_IMPLY(a_rsp_when_free, clock, reset, rsp_valid, !busy)
   `RRTS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `RRTS_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid,
      rsp_data.ready_count <= 5'd16 && rsp_data.woken_count <= rsp_data.ready_count)
endmodule

### rtl/rrts_list.sv
// Ordered id list storage with one read, one write and a membership bitmap.
module rrts_list (
   input  logic                          clock,
   input  logic                          reset,
   input  rrts_pkg::rrts_list_cmd_type   cmd,
   output rrts_pkg::id_type              rd_data,
   output logic [rrts_pkg::NUM_IDS-1:0]  member
);
   rrts_pkg::id_type                entry_ff [rrts_pkg::NUM_IDS];
   logic [rrts_pkg::NUM_IDS-1:0]    member_ff;
   logic [rrts_pkg::NUM_IDS-1:0]    member_in;

   // Entry storage; an entry must only be read after being written, which the list does not enforce.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // Membership bits track which ids are in the list.
   always_comb begin
      member_in = member_ff;
      if (cmd.clr_en) begin
         member_in[cmd.clr_id] = 1'b0;
      end
      if (cmd.set_en) begin
         member_in[cmd.set_id] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         member_ff <= '0;
      end else begin
         member_ff <= member_in;
      end
   end

   assign rd_data = entry_ff[cmd.rd_addr];
   assign member  = member_ff;
endmodule

### test/tb_top.sv
// Self-checking testbench for the round-robin task scheduler.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1850;

   // A directed row: the transaction, and optionally a typed-in status.
   typedef struct {
      rrts_pkg::req_type req;
      bit                fixed;
      rrts_pkg::rsp_type rsp;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   rrts_pkg::req_type req_data;
   logic              rsp_valid;
   rrts_pkg::rsp_type rsp_data;

   // Shadow scheduler state.
   logic [3:0]  sh_ring[rrts_pkg::NUM_IDS];
   int          sh_ring_len;
   logic [3:0]  sh_sleep[rrts_pkg::NUM_IDS];
   int          sh_sleep_len;
   logic [63:0] sh_deadline[rrts_pkg::NUM_IDS];
   logic [63:0] sh_now;
   logic [3:0]  sh_task;
   logic        sh_idle;

   rrts_pkg::rsp_type status_queue[$];
   stim_row_type      stim_rows[$];
   int      failures;
   int      accepted;
   int      checked;
   int      idle_cycles;
   int      woken_total;
   int      rejected_total;

   round_robin_task_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // Clock generation: 4 ns low, 4 ns high.
   always begin
      #4 clock = 1'b0;
      #4 clock = 1'b1;
   end

   function automatic int find_id(ref logic [3:0] list[rrts_pkg::NUM_IDS], input int len,
                                  input logic [3:0] id);
      for (int i = 0; i < len; i++)
         if (list[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_at(ref logic [3:0] list[rrts_pkg::NUM_IDS], ref int len,
                                   input int pos);
      if (pos < 0) return;
      for (int i = pos; i + 1 < len; i++) list[i] = list[i + 1];
      len--;
   endfunction

   function automatic bit add_tail(ref logic [3:0] list[rrts_pkg::NUM_IDS], ref int len,
                                   input logic [3:0] id);
      if (find_id(list, len, id) >= 0 || len >= rrts_pkg::NUM_IDS) return 1'b0;
      list[len] = id;
      len++;
      return 1'b1;
   endfunction

   // Apply one transaction to the shadow state and return the status.
   function automatic rrts_pkg::rsp_type schedule_status(rrts_pkg::req_type r);
      rrts_pkg::rsp_type s;
      int         woken;
      bit         rej;
      int         i;
      logic [3:0] head;
      logic [3:0] t;
      woken = 0;
      rej = 1'b0;
      case (r.action)
         rrts_pkg::ACT_READY:   rej = !add_tail(sh_ring, sh_ring_len, r.task_id);
         rrts_pkg::ACT_UNREADY:
            drop_at(sh_ring, sh_ring_len, find_id(sh_ring, sh_ring_len, r.task_id));
         rrts_pkg::ACT_SCHED: begin
            if (sh_ring_len == 0) begin
               sh_idle = 1'b1;
               sh_task = '0;
            end else begin
               head = sh_ring[0];
               for (i = 0; i + 1 < sh_ring_len; i++) sh_ring[i] = sh_ring[i + 1];
               sh_ring[sh_ring_len - 1] = head;
               sh_task = sh_ring[0];
               sh_idle = 1'b0;
            end
         end
         rrts_pkg::ACT_SLEEP: begin
            if (sh_idle) begin
               rej = 1'b1;
            end else begin
               drop_at(sh_ring, sh_ring_len, find_id(sh_ring, sh_ring_len, sh_task));
               drop_at(sh_sleep, sh_sleep_len, find_id(sh_sleep, sh_sleep_len, sh_task));
               sh_deadline[sh_task] = sh_now + 64'(r.amount_ms);
               void'(add_tail(sh_sleep, sh_sleep_len, sh_task));
            end
         end
         rrts_pkg::ACT_CANCEL:
            drop_at(sh_sleep, sh_sleep_len, find_id(sh_sleep, sh_sleep_len, r.task_id));
         rrts_pkg::ACT_TICK: begin
            sh_now = sh_now + 64'(r.amount_ms);
            i = 0;
            while (i < sh_sleep_len) begin
               t = sh_sleep[i];
               if (sh_now > sh_deadline[t]) begin
                  drop_at(sh_sleep, sh_sleep_len, i);
                  if (add_tail(sh_ring, sh_ring_len, t)) woken++;
               end else begin
                  i++;
               end
            end
         end
         default: ;
      endcase
      s.current_task = sh_idle ? 4'd0 : sh_task;
      s.current_idle = sh_idle;
      s.ready_count  = 5'(sh_ring_len);
      s.woken_count  = 5'(woken);
      s.rejected     = rej;
      return s;
   endfunction

   // Compare each status strobe with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (status_queue.size() == 0) begin
            $display("%0t: unexpected status, actual %p", $realtime, rsp_data);
            failures++;
         end else begin
            rrts_pkg::rsp_type e;
            e = status_queue.pop_front();
            checked++;
            woken_total += rsp_data.woken_count;
            rejected_total += rsp_data.rejected;
            if (rsp_data.current_task !== e.current_task)
               $display("%0t: current_task expected %0d actual %0d", $realtime,
                        e.current_task, rsp_data.current_task);
            if (rsp_data.current_idle !== e.current_idle)
               $display("%0t: current_idle expected %0d actual %0d", $realtime,
                        e.current_idle, rsp_data.current_idle);
            if (rsp_data.ready_count !== e.ready_count)
               $display("%0t: ready_count expected %0d actual %0d", $realtime,
                        e.ready_count, rsp_data.ready_count);
            if (rsp_data.woken_count !== e.woken_count)
               $display("%0t: woken_count expected %0d actual %0d", $realtime,
                        e.woken_count, rsp_data.woken_count);
            if (rsp_data.rejected !== e.rejected)
               $display("%0t: rejected expected %0d actual %0d", $realtime,
                        e.rejected, rsp_data.rejected);
            if (rsp_data !== e) failures++;
         end
      end
   end

   // Watchdog: count cycles with no transaction moving either way.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // Drive one transaction after a random gap and wait until the scheduler is no longer busy.
   // start stays high after acceptance so a zero gap gives back-to-back items.
   task automatic send(rrts_pkg::req_type r, bit fixed, rrts_pkg::rsp_type want);
      rrts_pkg::rsp_type p;
      int gap;
      gap = (accepted % 97 < 20) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = schedule_status(r);
      if (fixed && p !== want) begin
         $display("%0t: table row disagrees, expected %p actual %p", $realtime, want, p);
         failures++;
      end
      status_queue.insert(status_queue.size(), p);
      accepted++;
   endtask

   // Drop start and wait until every expected status has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (status_queue.size() != 0) @(posedge clock);
   endtask

   function automatic rrts_pkg::req_type mk(logic [2:0] a, logic [3:0] id, logic [31:0] amt);
      rrts_pkg::req_type r;
      r.action = a;
      r.task_id = id;
      r.amount_ms = amt;
      return r;
   endfunction

   function automatic rrts_pkg::rsp_type st(logic [3:0] t, logic i, logic [4:0] rc,
                                            logic [4:0] w, logic rj);
      rrts_pkg::rsp_type s;
      s.current_task = t;
      s.current_idle = i;
      s.ready_count = rc;
      s.woken_count = w;
      s.rejected = rj;
      return s;
   endfunction

   // Append one row to the directed table.
   task automatic add_row(rrts_pkg::req_type r, bit fixed, rrts_pkg::rsp_type s);
      stim_row_type row;
      row.req = r;
      row.fixed = fixed;
      row.rsp = s;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   // Random transaction, weighted toward useful scheduler traffic.
   function automatic rrts_pkg::req_type rand_req();
      int k;
      logic [31:0] amt;
      k = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
         0: amt = $urandom();
         1: amt = 32'hFFFF_FFFF;
         default: amt = $urandom_range(0, 40);
      endcase
      if (k < 25) return mk(rrts_pkg::ACT_READY, 4'($urandom_range(0, 15)), $urandom());
      if (k < 33) return mk(rrts_pkg::ACT_UNREADY, 4'($urandom_range(0, 15)), $urandom());
      if (k < 55) return mk(rrts_pkg::ACT_SCHED, 4'($urandom_range(0, 15)), $urandom());
      if (k < 70) return mk(rrts_pkg::ACT_SLEEP, 4'($urandom_range(0, 15)), amt);
      if (k < 76) return mk(rrts_pkg::ACT_CANCEL, 4'($urandom_range(0, 15)), $urandom());
      if (k < 97) return mk(rrts_pkg::ACT_TICK, 4'($urandom_range(0, 15)), amt);
      return mk(3'($urandom_range(6, 7)), 4'($urandom_range(0, 15)), $urandom());
   endfunction

   // Main sequence.
   initial begin
      rrts_pkg::rsp_type none;
      none = '0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      failures = 0;
      accepted = 0;
      checked = 0;
      idle_cycles = 0;
      woken_total = 0;
      rejected_total = 0;
      sh_ring_len = 0;
      sh_sleep_len = 0;
      sh_now = '0;
      sh_task = '0;
      sh_idle = 1'b1;
      foreach (sh_deadline[i]) sh_deadline[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table: edges, every action and the special cases.
      add_row(mk(rrts_pkg::ACT_SCHED, 4'd0, 32'd0), 1, st(0, 1, 0, 0, 0));
      add_row(mk(rrts_pkg::ACT_SLEEP, 4'd0, 32'd5), 1, st(0, 1, 0, 0, 1));
      add_row(mk(rrts_pkg::ACT_READY, 4'd0, 32'd0), 1, st(0, 1, 1, 0, 0));
      add_row(mk(rrts_pkg::ACT_READY, 4'd15, 32'hFFFF_FFFF), 1, st(0, 1, 2, 0, 0));
      add_row(mk(rrts_pkg::ACT_READY, 4'd15, 32'd0), 1, st(0, 1, 2, 0, 1));
      add_row(mk(rrts_pkg::ACT_UNREADY, 4'd7, 32'd0), 1, st(0, 1, 2, 0, 0));
      add_row(mk(rrts_pkg::ACT_SCHED, 4'd0, 32'd0), 1, st(15, 0, 2, 0, 0));
      add_row(mk(rrts_pkg::ACT_UNREADY, 4'd15, 32'd0), 1, st(15, 0, 1, 0, 0));
      add_row(mk(rrts_pkg::ACT_SLEEP, 4'd0, 32'd3), 0, none);
      add_row(mk(rrts_pkg::ACT_SLEEP, 4'd0, 32'hFFFF_FFFF), 0, none);
      add_row(mk(rrts_pkg::ACT_CANCEL, 4'd9, 32'd0), 0, none);
      add_row(mk(rrts_pkg::ACT_TICK, 4'd0, 32'hFFFF_FFFF), 0, none);
      add_row(mk(rrts_pkg::ACT_TICK, 4'd0, 32'd1), 0, none);
      add_row(mk(rrts_pkg::ACT_SCHED, 4'd0, 32'd0), 0, none);
      add_row(mk(rrts_pkg::ACT_SLEEP, 4'd0, 32'd0), 0, none);
      add_row(mk(rrts_pkg::ACT_READY, 4'd0, 32'd0), 0, none);
      add_row(mk(rrts_pkg::ACT_TICK, 4'd0, 32'd1), 0, none);
      add_row(mk(rrts_pkg::ACT_SLEEP, 4'd0, 32'd2), 0, none);
      add_row(mk(rrts_pkg::ACT_CANCEL, 4'd15, 32'd0), 0, none);
      add_row(mk(3'd6, 4'd3, 32'd0), 0, none);
      add_row(mk(3'd7, 4'd12, 32'hAAAA_5555), 0, none);
      // Advance the clock by the largest 32-bit tick amount.
      add_row(mk(rrts_pkg::ACT_TICK, 4'd0, 32'hFFFF_FFFF), 0, none);
      foreach (stim_rows[i]) send(stim_rows[i].req, stim_rows[i].fixed, stim_rows[i].rsp);

      // Hold the sender until every status is back.
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send(rand_req(), 1'b0, none);
         if (n == RANDOM_ITEMS / 2)
            drain();
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Ran %0d transactions, %0d statuses checked.", accepted, checked);
      $display("Sleepers woken: %0d, rejected transactions: %0d.", woken_total,
               rejected_total);
      if (failures == 0 && status_queue.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule
